>>> hdl/joint_feedback_drive_with_safety_macros.svh
// ----------------------------------------------------------------------------
// joint feedback drive assertion macros
// concurrent assertion helpers for the drive safety module, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef JOINT_FEEDBACK_DRIVE_WITH_SAFETY_MACROS_SVH
`define JOINT_FEEDBACK_DRIVE_WITH_SAFETY_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every edge out of reset
`define JFD_ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("jfd assertion failed");

// antecedent implies consequent in the same cycle
`define JFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jfd assertion failed");

// antecedent implies consequent in the next cycle
`define JFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jfd assertion failed");

`else

`define JFD_ASSERT_HOLDS(label, clk, rst_n, expr)
`define JFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define JFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/jfd_pkg.sv
// ----------------------------------------------------------------------------
// jfd_pkg
// types, constants and the cosine table of the joint feedback drive
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jfd_pkg;

    // cosine table depth and index widths
    localparam int COS_TABLE_DEPTH = 256;
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
    localparam int COS_RAW_W       = $clog2(COS_TABLE_DEPTH + 1);
    localparam int COS_PROD_W      = 12 + COS_RAW_W;

    // angle and rate conversion, q24
    localparam logic signed [31:0] ANG_PER_TICK  = 32'sd25736;
    localparam logic signed [31:0] ANG_OFFSET    = 32'sd5872026;
    localparam logic signed [35:0] RATE_PER_TICK = 36'sd257359;

    // duty scaling: drive / (3 * 2^24), rounded half away from zero
    localparam logic [42:0] DUTY_HALF   = 43'd25165824;
    localparam logic [18:0] DIV3_RECIP  = 19'd174763;
    localparam int          DIV3_SHIFT  = 19;
    localparam int          DUTY_MAX    = 16384;

    // safety chain limits
    localparam logic [1:0] ZERO_PULSES     = 2'd2;
    localparam logic [3:0] STALL_LIMIT     = 4'd10;
    localparam logic [3:0] STALL_COUNT_MAX = 4'd15;

    // configuration port
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_POSITION_GAIN    = 3'd0,
        REG_VELOCITY_GAIN    = 3'd1,
        REG_FEEDFORWARD_GAIN = 3'd2,
        REG_GRAVITY_GAIN     = 3'd3,
        REG_TOP_LIMIT        = 3'd4,
        REG_STALL_SPEED      = 3'd5,
        REG_STALL_VOLTAGE    = 3'd6,
        REG_MAX_VOLTAGE      = 3'd7
    } t_reg_index;

    typedef enum logic [2:0] {
        SAFE_NONE   = 3'd0,
        SAFE_TOP    = 3'd1,
        SAFE_BOTTOM = 3'd2,
        SAFE_CLIP   = 3'd3,
        SAFE_STALL  = 3'd4
    } t_safety_code;

    // configuration registers
    typedef struct packed {
        logic        [15:0] position_gain;
        logic        [15:0] velocity_gain;
        logic        [15:0] feedforward_gain;
        logic        [14:0] gravity_gain;
        logic signed [15:0] top_limit;
        logic        [14:0] stall_speed;
        logic        [14:0] stall_voltage;
        logic        [14:0] max_voltage;
    } t_cfg;

    // accepted input item
    typedef struct packed {
        logic               func;
        logic signed [15:0] encoder_ticks;
        logic signed [15:0] encoder_rate;
        logic               at_bottom;
        logic signed [15:0] ref_position;
        logic signed [15:0] ref_velocity;
        logic signed [15:0] manual_voltage;
    } t_in_item;

    // converted measurements and errors
    typedef struct packed {
        logic               func;
        logic               at_bottom;
        logic signed [31:0] ang;
        logic signed [35:0] vel;
        logic signed [31:0] err_p;
        logic signed [35:0] err_v;
        logic signed [15:0] ref_velocity;
        logic signed [15:0] cos_val;
        logic signed [15:0] manual_voltage;
    } t_front;

    // gain products
    typedef struct packed {
        logic               func;
        logic               at_bottom;
        logic signed [31:0] ang;
        logic signed [35:0] vel;
        logic signed [48:0] p_pos;
        logic signed [52:0] p_vel;
        logic signed [32:0] p_ff;
        logic signed [31:0] p_grav;
        logic signed [15:0] manual_voltage;
    } t_prod;

    // limited drive and status, q36
    typedef struct packed {
        logic signed [42:0] u;
        t_safety_code       code;
        logic               zero_request;
        logic               stall_latched;
        logic               initialized;
    } t_drive;

    // cosine table
    localparam logic signed [63:0] ONE_Q28     = 64'sd268435456;
    localparam logic signed [63:0] PI_Q28      = 64'sd843314857;
    localparam logic signed [63:0] HALF_PI_Q28 = 64'sd421657428;
    localparam logic signed [63:0] TWO_PI_Q28  = 64'sd1686629713;
    localparam logic signed [63:0] OFFSET_Q28  = 64'sd93952410;

    typedef logic signed [15:0] t_cos_table [COS_TABLE_DEPTH];

    // cos in q14 of a q28 angle in [0, 2pi + offset), taylor series in q28
    function automatic logic signed [15:0] f_cos_q14(input logic signed [63:0] a_in);
        logic signed [63:0] a;
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] t;
        logic signed [63:0] r;
        logic               neg;
        a   = a_in;
        neg = 1'b0;
        if (a > PI_Q28) begin
            a = a - TWO_PI_Q28;
        end
        x = (a < 0) ? -a : a;
        if (x > HALF_PI_Q28) begin
            x   = PI_Q28 - x;
            neg = 1'b1;
        end
        x2 = (x * x) / ONE_Q28;
        t  = ONE_Q28;
        for (int k = 6; k >= 1; k--) begin
            t = ONE_Q28 - ((x2 * t) / ONE_Q28) / 64'((2 * k - 1) * (2 * k));
        end
        if (neg) begin
            t = -t;
        end
        r = (((t < 0) ? -t : t) + 64'sd8192) / 64'sd16384;
        return (t < 0) ? 16'(-r) : 16'(r);
    endfunction

    function automatic t_cos_table f_build_cos();
        t_cos_table tab;
        for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            tab[i] = f_cos_q14((TWO_PI_Q28 * 64'(i)) / COS_TABLE_DEPTH + OFFSET_Q28);
        end
        return tab;
    endfunction

    localparam t_cos_table COS_TABLE = f_build_cos();

endpackage

`default_nettype wire

>>> hdl/jfd_regs.sv
// ----------------------------------------------------------------------------
// jfd_regs
// apb configuration registers of the joint feedback drive
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jfd_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [jfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output jfd_pkg::t_cfg                       o_cfg
);
    import jfd_pkg::*;

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign w_index = t_reg_index'(paddr[CFG_ADDR_W-1:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.position_gain    <= 16'd42271;
            r_cfg.velocity_gain    <= 16'd258;
            r_cfg.feedforward_gain <= 16'd20825;
            r_cfg.gravity_gain     <= 15'd1331;
            r_cfg.top_limit        <= 16'sd6472;
            r_cfg.stall_speed      <= 15'd205;
            r_cfg.stall_voltage    <= 15'd4096;
            r_cfg.max_voltage      <= 15'd12288;
        end else if (w_write) begin
            case (w_index)
                REG_POSITION_GAIN:    r_cfg.position_gain    <= pwdata[15:0];
                REG_VELOCITY_GAIN:    r_cfg.velocity_gain    <= pwdata[15:0];
                REG_FEEDFORWARD_GAIN: r_cfg.feedforward_gain <= pwdata[15:0];
                REG_GRAVITY_GAIN:     r_cfg.gravity_gain     <= pwdata[14:0];
                REG_TOP_LIMIT:        r_cfg.top_limit        <= pwdata[15:0];
                REG_STALL_SPEED:      r_cfg.stall_speed      <= pwdata[14:0];
                REG_STALL_VOLTAGE:    r_cfg.stall_voltage    <= pwdata[14:0];
                REG_MAX_VOLTAGE:      r_cfg.max_voltage      <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_index)
            REG_POSITION_GAIN:    prdata = 32'(r_cfg.position_gain);
            REG_VELOCITY_GAIN:    prdata = 32'(r_cfg.velocity_gain);
            REG_FEEDFORWARD_GAIN: prdata = 32'(r_cfg.feedforward_gain);
            REG_GRAVITY_GAIN:     prdata = 32'(r_cfg.gravity_gain);
            REG_TOP_LIMIT:        prdata = 32'(r_cfg.top_limit);
            REG_STALL_SPEED:      prdata = 32'(r_cfg.stall_speed);
            REG_STALL_VOLTAGE:    prdata = 32'(r_cfg.stall_voltage);
            REG_MAX_VOLTAGE:      prdata = 32'(r_cfg.max_voltage);
            default:              prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/jfd_front.sv
// ----------------------------------------------------------------------------
// jfd_front
// encoder conversion, tracking errors and cosine lookup stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jfd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire jfd_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output jfd_pkg::t_front        o_item
);
    import jfd_pkg::*;

    logic                 r_valid;
    t_front               r_item;
    t_front               n_item;
    logic [11:0]          w_phase;
    logic [COS_PROD_W-1:0] w_idx_prod;
    logic [COS_RAW_W-1:0] w_idx_raw;
    logic [COS_RAW_W-1:0] w_idx;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // cosine index from the negated encoder phase within one turn
    assign w_phase    = 12'd0 - i_item.encoder_ticks[11:0];
    assign w_idx_prod = COS_PROD_W'(w_phase) * COS_PROD_W'(COS_TABLE_DEPTH);
    assign w_idx_raw  = w_idx_prod[COS_PROD_W-1:12];
    assign w_idx      = (w_idx_raw >= COS_RAW_W'(COS_TABLE_DEPTH)) ?
                        COS_RAW_W'(COS_TABLE_DEPTH - 1) : w_idx_raw;

    // angle and rate in q24, errors against the reference
    always_comb begin
        n_item.func           = i_item.func;
        n_item.at_bottom      = i_item.at_bottom;
        n_item.ang            = ANG_OFFSET - 32'(i_item.encoder_ticks) * ANG_PER_TICK;
        n_item.vel            = 36'sd0 - 36'(i_item.encoder_rate) * RATE_PER_TICK;
        n_item.err_p          = (32'(i_item.ref_position) <<< 12) - n_item.ang;
        n_item.err_v          = (36'(i_item.ref_velocity) <<< 12) - n_item.vel;
        n_item.ref_velocity   = i_item.ref_velocity;
        n_item.cos_val        = COS_TABLE[w_idx[COS_IDX_W-1:0]];
        n_item.manual_voltage = i_item.manual_voltage;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/jfd_gain.sv
// ----------------------------------------------------------------------------
// jfd_gain
// gain multiplier stage: position, velocity, feedforward and gravity terms
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jfd_gain (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire jfd_pkg::t_cfg   i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire jfd_pkg::t_front i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output jfd_pkg::t_prod       o_item
);
    import jfd_pkg::*;

    logic  r_valid;
    t_prod r_item;
    t_prod n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // four independent products, gains zero extended
    always_comb begin
        n_item.func           = i_item.func;
        n_item.at_bottom      = i_item.at_bottom;
        n_item.ang            = i_item.ang;
        n_item.vel            = i_item.vel;
        n_item.p_pos          = 49'(signed'({1'b0, i_cfg.position_gain})) * 49'(i_item.err_p);
        n_item.p_vel          = 53'(signed'({1'b0, i_cfg.velocity_gain})) * 53'(i_item.err_v);
        n_item.p_ff           = 33'(signed'({1'b0, i_cfg.feedforward_gain}))
                              * 33'(i_item.ref_velocity);
        n_item.p_grav         = 32'(signed'({1'b0, i_cfg.gravity_gain})) * 32'(i_item.cos_val);
        n_item.manual_voltage = i_item.manual_voltage;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/jfd_safety.sv
// ----------------------------------------------------------------------------
// jfd_safety
// drive sum and safety chain: top limit, bottom zeroing, clip, stall cutoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "joint_feedback_drive_with_safety_macros.svh"

module jfd_safety (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire jfd_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire jfd_pkg::t_prod i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output jfd_pkg::t_drive     o_item
);
    import jfd_pkg::*;

    logic               r_valid;
    t_drive             r_drive;
    t_drive             n_drive;
    logic [3:0]         r_stall_count;
    logic [3:0]         n_stall_count;
    logic               r_stall_flag;
    logic               n_stall_flag;
    logic [1:0]         r_zero_count;
    logic [1:0]         n_zero_count;
    logic               r_init_done;
    logic               n_init_done;
    logic               w_take;
    logic signed [55:0] w_sum;
    logic signed [55:0] w_u;
    logic signed [55:0] w_vmax;
    logic signed [55:0] w_u_mag;
    logic signed [35:0] w_vel_mag;
    logic               w_at_top;
    logic               w_still;
    t_safety_code       w_code;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_drive;
    assign w_take  = o_ready && i_valid;

    // closed loop sum in q36
    assign w_sum = 56'(i_item.p_pos) + 56'(i_item.p_vel)
                 + (56'(i_item.p_ff) <<< 12) + (56'(i_item.p_grav) <<< 12);

    assign w_vmax    = signed'(56'({i_cfg.max_voltage, 26'd0}));
    assign w_at_top  = 36'(i_item.ang) >= (36'(i_cfg.top_limit) <<< 12);
    assign w_vel_mag = (i_item.vel < 0) ? -i_item.vel : i_item.vel;

    // safety chain, the last stage that acts sets the code
    always_comb begin
        w_u           = i_item.func ? (56'(i_item.manual_voltage) <<< 26) : w_sum;
        w_code        = SAFE_NONE;
        n_zero_count  = r_zero_count;
        n_init_done   = r_init_done;
        n_stall_flag  = r_stall_flag;
        n_drive.zero_request = 1'b0;

        // top soft limit
        if (w_at_top && w_u > 0) begin
            w_u    = '0;
            w_code = SAFE_TOP;
        end

        // bottom sensor: zeroing requests, then initialized
        if (i_item.at_bottom) begin
            if (r_zero_count < ZERO_PULSES) begin
                n_drive.zero_request = 1'b1;
                n_zero_count         = r_zero_count + 2'd1;
            end else begin
                n_init_done = 1'b1;
            end
            if (i_item.ang < 0 && w_u < 0) begin
                w_u    = '0;
                w_code = SAFE_BOTTOM;
            end
        end

        // symmetric clip
        if (w_u > w_vmax) begin
            w_u    = w_vmax;
            w_code = SAFE_CLIP;
        end else if (w_u < -w_vmax) begin
            w_u    = -w_vmax;
            w_code = SAFE_CLIP;
        end

        // stall counting and cutoff
        w_u_mag = (w_u < 0) ? -w_u : w_u;
        w_still = (w_vel_mag <= signed'(36'({i_cfg.stall_speed, 12'd0})))
               && (w_u_mag > signed'(56'({i_cfg.stall_voltage, 26'd0})));
        if (w_still) begin
            n_stall_count = (r_stall_count < STALL_COUNT_MAX) ?
                            r_stall_count + 4'd1 : r_stall_count;
        end else begin
            n_stall_count = 4'd0;
        end
        if (n_stall_count > STALL_LIMIT) begin
            n_stall_flag = 1'b1;
            w_u          = '0;
            w_code       = SAFE_STALL;
        end

        n_drive.u             = 43'(w_u);
        n_drive.code          = w_code;
        n_drive.stall_latched = n_stall_flag;
        n_drive.initialized   = n_init_done;
    end

    // tick state, advanced once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_count <= 4'd0;
            r_stall_flag  <= 1'b0;
            r_zero_count  <= 2'd0;
            r_init_done   <= 1'b0;
        end else if (w_take) begin
            r_stall_count <= n_stall_count;
            r_stall_flag  <= n_stall_flag;
            r_zero_count  <= n_zero_count;
            r_init_done   <= n_init_done;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_drive <= n_drive;
        end
    end

    // state consistency checks
    `JFD_ASSERT_HOLDS(a_zero_count_bound, i_clk, i_rst_n, r_zero_count <= ZERO_PULSES)
    `JFD_ASSERT_IMPLIES(a_init_after_zeroing, i_clk, i_rst_n, r_init_done, r_zero_count == ZERO_PULSES)
    `JFD_ASSERT_NEXT(a_stall_flag_sticky, i_clk, i_rst_n, r_stall_flag, r_stall_flag)
    `JFD_ASSERT_IMPLIES(a_count_sets_flag, i_clk, i_rst_n, r_stall_count > STALL_LIMIT, r_stall_flag)
    `JFD_ASSERT_IMPLIES(a_stall_cuts_drive, i_clk, i_rst_n, r_valid && r_drive.code == SAFE_STALL, r_drive.u == '0)

endmodule

`default_nettype wire

>>> hdl/jfd_duty.sv
// ----------------------------------------------------------------------------
// jfd_duty
// duty scaling stage and output register: rounded, saturated, negated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jfd_duty (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire jfd_pkg::t_drive i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [23:0]          o_data
);
    import jfd_pkg::*;

    logic               r_valid;
    logic [23:0]        r_data;
    logic [23:0]        n_data;
    logic signed [42:0] w_mag;
    logic [42:0]        w_round;
    logic [18:0]        w_quot24;
    logic [37:0]        w_prod;
    logic [18:0]        w_quot;
    logic [15:0]        w_sat;
    logic [15:0]        w_duty;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // |u| / (3 * 2^24): shift first, then divide by three via reciprocal
    assign w_mag    = (i_item.u < 0) ? -i_item.u : i_item.u;
    assign w_round  = 43'(w_mag) + DUTY_HALF;
    assign w_quot24 = w_round[42:24];
    assign w_prod   = 38'(w_quot24) * 38'(DIV3_RECIP);
    assign w_quot   = w_prod[37:DIV3_SHIFT];
    assign w_sat    = (w_quot > 19'(DUTY_MAX)) ? 16'(DUTY_MAX) : w_quot[15:0];
    assign w_duty   = (i_item.u > 0) ? 16'd0 - w_sat : w_sat;

    // result packing, highest field first
    assign n_data = {2'b00, i_item.initialized, i_item.stall_latched, i_item.zero_request,
                     i_item.code, w_duty};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/joint_feedback_drive_with_safety.sv
// ----------------------------------------------------------------------------
// joint_feedback_drive_with_safety
// Joint drive controller: one item per control tick gives one duty result.
// Each item passes five registers (input, conversion and cosine lookup, gain
// multipliers, drive sum with safety chain, duty scaling) in that order, and
// a new item can be taken every cycle while the output is not stalled; each
// stage holds its own valid bit, so a stalled output only backs up as far as
// the first empty stage. The cosine of the joint angle comes from a constant
// table of 256 entries. Registers are written over the apb port at byte
// address 4 * index and must only change while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module joint_feedback_drive_with_safety (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // apb configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [jfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    // input items
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // encoder_ticks[15:0], encoder_rate[31:16], at_bottom[32],
    // ref_position[48:33], ref_velocity[64:49], manual_voltage[80:65]
    input  wire logic [87:0]                    s_axis_tdata,
    // func[0]
    input  wire logic [0:0]                     s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // motor_duty[15:0], safety_code[18:16], zero_request[19],
    // stall_latched[20], initialized[21]
    output logic      [23:0]                    m_axis_tdata
);
    import jfd_pkg::*;

    t_cfg     w_cfg;
    logic     r_in_valid;
    t_in_item r_in;
    t_in_item n_in;
    logic     w_front_ready;
    logic     w_front_valid;
    t_front   w_front;
    logic     w_gain_ready;
    logic     w_gain_valid;
    t_prod    w_prod;
    logic     w_safety_ready;
    logic     w_safety_valid;
    t_drive   w_drive;
    logic     w_duty_ready;

    // configuration registers
    jfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input item unpacking
    always_comb begin
        n_in.func           = s_axis_tuser[0];
        n_in.encoder_ticks  = s_axis_tdata[15:0];
        n_in.encoder_rate   = s_axis_tdata[31:16];
        n_in.at_bottom      = s_axis_tdata[32];
        n_in.ref_position   = s_axis_tdata[48:33];
        n_in.ref_velocity   = s_axis_tdata[64:49];
        n_in.manual_voltage = s_axis_tdata[80:65];
    end

    assign s_axis_tready = !r_in_valid || w_front_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= n_in;
        end
    end

    // conversion and cosine lookup
    jfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (w_front_ready),
        .i_item  (r_in),
        .o_valid (w_front_valid),
        .i_ready (w_gain_ready),
        .o_item  (w_front)
    );

    // gain products
    jfd_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_front_valid),
        .o_ready (w_gain_ready),
        .i_item  (w_front),
        .o_valid (w_gain_valid),
        .i_ready (w_safety_ready),
        .o_item  (w_prod)
    );

    // drive sum and safety chain
    jfd_safety u_safety (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_gain_valid),
        .o_ready (w_safety_ready),
        .i_item  (w_prod),
        .o_valid (w_safety_valid),
        .i_ready (w_duty_ready),
        .o_item  (w_drive)
    );

    // duty scaling and output register
    jfd_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_safety_valid),
        .o_ready (w_duty_ready),
        .i_item  (w_drive),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> test/joint_feedback_drive_with_safety_tb.sv
// ----------------------------------------------------------------------------
// joint_feedback_drive_with_safety_tb
// Self-checking bench for the joint drive: every accepted tick item is run
// through a bench-side model of the feedback law and safety chain, and each
// duty item from the block is compared field by field, in order. Register
// writes are read back over apb and only happen while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joint_feedback_drive_with_safety_tb;

    import jfd_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    // fixed-point constants of the drive law
    localparam longint TICK_ANGLE_Q24 = 25736;
    localparam longint ANGLE_BIAS_Q24 = 5872026;
    localparam longint TICK_RATE_Q24  = 257359;
    localparam longint VOLT_TO_Q36    = 67108864;
    localparam longint DUTY_DIVISOR   = 50331648;
    localparam longint DUTY_LIMIT     = 16384;
    localparam longint Q28_ONE        = 268435456;
    localparam longint Q28_PI         = 843314857;
    localparam longint Q28_HALF_PI    = 421657428;
    localparam longint Q28_TWO_PI     = 1686629713;
    localparam longint Q28_BIAS       = 93952410;

    // one expected duty item
    typedef struct {
        logic signed [15:0] motor_duty;
        t_safety_code       safety_code;
        logic               zero_request;
        logic               stall_latched;
        logic               initialized;
    } t_duty_item;

    // clock, reset and dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // encoder_ticks, encoder_rate, at_bottom, ref_position, ref_velocity,
    // manual_voltage, zero pad
    logic [87:0] s_axis_tdata = '0;
    // func
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // motor_duty, safety_code, zero_request, stall_latched, initialized, pad
    logic [23:0] m_axis_tdata;

    // bench-side copy of registers and loop state
    t_cfg        drive_cfg;
    logic [3:0]  stall_ticks;
    logic        stall_seen;
    logic [1:0]  zero_pulses;
    logic        homed;
    longint      cosine_lut [COS_TABLE_DEPTH];

    t_duty_item  duty_expected [$];
    t_duty_item  duty_want;
    int          error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    joint_feedback_drive_with_safety i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // cosine in q14 of a q28 angle, series evaluated in q28
    function automatic longint cosine_q14(longint angle);
        longint x;
        longint x2;
        longint t;
        longint r;
        bit     flip;
        int     k;
        flip = 1'b0;
        if (angle > Q28_PI) begin
            angle = angle - Q28_TWO_PI;
        end
        x = magnitude(angle);
        if (x > Q28_HALF_PI) begin
            x = Q28_PI - x;
            flip = 1'b1;
        end
        x2 = (x * x) / Q28_ONE;
        t = Q28_ONE;
        for (k = 6; k >= 1; k--) begin
            t = Q28_ONE - ((x2 * t) / Q28_ONE) / longint'((2 * k - 1) * (2 * k));
        end
        if (flip) begin
            t = -t;
        end
        r = (magnitude(t) + 8192) / 16384;
        return (t < 0) ? -r : r;
    endfunction

    // drive law and safety chain for one tick, advances the loop state
    function automatic t_duty_item predict_duty(t_in_item tick);
        t_duty_item res;
        longint     ticks;
        longint     rate;
        longint     angle;
        longint     speed;
        longint     drive;
        longint     vlimit;
        longint     duty;
        int unsigned phase;
        int unsigned slot;
        ticks = longint'(tick.encoder_ticks);
        rate  = longint'(tick.encoder_rate);
        angle = -ticks * TICK_ANGLE_Q24 + ANGLE_BIAS_Q24;
        speed = -rate * TICK_RATE_Q24;
        res.safety_code  = SAFE_NONE;
        res.zero_request = 1'b0;

        if (tick.func) begin
            drive = longint'(tick.manual_voltage) * VOLT_TO_Q36;
        end else begin
            phase = int'((-ticks) & 64'd4095);
            slot  = (phase * COS_TABLE_DEPTH) >> 12;
            drive = longint'(drive_cfg.position_gain)
                        * (longint'(tick.ref_position) * 4096 - angle)
                  + longint'(drive_cfg.velocity_gain)
                        * (longint'(tick.ref_velocity) * 4096 - speed)
                  + longint'(drive_cfg.feedforward_gain) * longint'(tick.ref_velocity) * 4096
                  + longint'(drive_cfg.gravity_gain) * cosine_lut[slot] * 4096;
        end

        // top soft limit
        if (angle >= longint'(drive_cfg.top_limit) * 4096 && drive > 0) begin
            drive = 0;
            res.safety_code = SAFE_TOP;
        end

        // bottom hall sensor, zeroing requests then homed
        if (tick.at_bottom) begin
            if (zero_pulses < 2) begin
                res.zero_request = 1'b1;
                zero_pulses = zero_pulses + 1'b1;
            end else begin
                homed = 1'b1;
            end
            if (angle < 0 && drive < 0) begin
                drive = 0;
                res.safety_code = SAFE_BOTTOM;
            end
        end

        // symmetric clip
        vlimit = longint'(drive_cfg.max_voltage) * VOLT_TO_Q36;
        if (drive > vlimit) begin
            drive = vlimit;
            res.safety_code = SAFE_CLIP;
        end else if (drive < -vlimit) begin
            drive = -vlimit;
            res.safety_code = SAFE_CLIP;
        end

        // stall detection and cutoff
        if (magnitude(speed) <= longint'(drive_cfg.stall_speed) * 4096 &&
            magnitude(drive) > longint'(drive_cfg.stall_voltage) * VOLT_TO_Q36) begin
            if (stall_ticks < 4'd15) begin
                stall_ticks = stall_ticks + 1'b1;
            end
        end else begin
            stall_ticks = '0;
        end
        if (stall_ticks > 4'd10) begin
            stall_seen = 1'b1;
            drive = 0;
            res.safety_code = SAFE_STALL;
        end

        // negated duty, rounded half away from zero
        duty = (magnitude(drive) + DUTY_DIVISOR / 2) / DUTY_DIVISOR;
        if (duty > DUTY_LIMIT) begin
            duty = DUTY_LIMIT;
        end
        if (drive > 0) begin
            duty = -duty;
        end
        res.motor_duty    = 16'(duty);
        res.stall_latched = stall_seen;
        res.initialized   = homed;
        return res;
    endfunction

    function automatic t_in_item make_tick(bit func, int ticks, int rate, bit bottom,
                                           int ref_pos, int ref_vel, int manual);
        t_in_item t;
        t.func           = func;
        t.encoder_ticks  = 16'(ticks);
        t.encoder_rate   = 16'(rate);
        t.at_bottom      = bottom;
        t.ref_position   = 16'(ref_pos);
        t.ref_velocity   = 16'(ref_vel);
        t.manual_voltage = 16'(manual);
        return t;
    endfunction

    // send one tick item, random gaps before it
    task automatic send_tick(input t_in_item tick);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tick.func;
        s_axis_tdata  <= {7'b0, tick.manual_voltage, tick.ref_velocity, tick.ref_position,
                          tick.at_bottom, tick.encoder_rate, tick.encoder_ticks};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        duty_expected.push_back(predict_duty(tick));
    endtask

    // stop sending and let the pipe empty
    task automatic drain_pipe();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (duty_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write, then read back
    task automatic write_register(input t_reg_index idx, input logic [31:0] value);
        logic [31:0] mask;
        drain_pipe();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        case (idx)
            REG_POSITION_GAIN: begin
                drive_cfg.position_gain = value[15:0];
                mask = 32'h0000_ffff;
            end
            REG_VELOCITY_GAIN: begin
                drive_cfg.velocity_gain = value[15:0];
                mask = 32'h0000_ffff;
            end
            REG_FEEDFORWARD_GAIN: begin
                drive_cfg.feedforward_gain = value[15:0];
                mask = 32'h0000_ffff;
            end
            REG_GRAVITY_GAIN: begin
                drive_cfg.gravity_gain = value[14:0];
                mask = 32'h0000_7fff;
            end
            REG_TOP_LIMIT: begin
                drive_cfg.top_limit = value[15:0];
                mask = 32'h0000_ffff;
            end
            REG_STALL_SPEED: begin
                drive_cfg.stall_speed = value[14:0];
                mask = 32'h0000_7fff;
            end
            REG_STALL_VOLTAGE: begin
                drive_cfg.stall_voltage = value[14:0];
                mask = 32'h0000_7fff;
            end
            default: begin
                drive_cfg.max_voltage = value[14:0];
                mask = 32'h0000_7fff;
            end
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            error_count++;
            $display("%0t readback reg %s expected %0d actual %0d",
                     $time, idx.name(), value & mask, prdata & mask);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write all registers, junk in the unused upper bits
    task automatic load_config(input t_cfg c);
        logic [31:0] v;
        v = $urandom(); v[15:0] = c.position_gain;    write_register(REG_POSITION_GAIN, v);
        v = $urandom(); v[15:0] = c.velocity_gain;    write_register(REG_VELOCITY_GAIN, v);
        v = $urandom(); v[15:0] = c.feedforward_gain; write_register(REG_FEEDFORWARD_GAIN, v);
        v = $urandom(); v[14:0] = c.gravity_gain;     write_register(REG_GRAVITY_GAIN, v);
        v = $urandom(); v[15:0] = c.top_limit;        write_register(REG_TOP_LIMIT, v);
        v = $urandom(); v[14:0] = c.stall_speed;      write_register(REG_STALL_SPEED, v);
        v = $urandom(); v[14:0] = c.stall_voltage;    write_register(REG_STALL_VOLTAGE, v);
        v = $urandom(); v[14:0] = c.max_voltage;      write_register(REG_MAX_VOLTAGE, v);
    endtask

    // mix of stall runs, realistic loop ticks, manual ticks and raw noise
    task automatic run_random_ticks(input int unsigned count);
        int unsigned sent;
        int unsigned kind;
        int unsigned run_len;
        int unsigned j;
        int          volts;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                run_len = $urandom_range(16, 8);
                for (j = 0; j < run_len; j++) begin
                    volts = rand_between(5000, 32767);
                    if ($urandom_range(1)) begin
                        volts = -volts;
                    end
                    send_tick(make_tick(1'b1, rand_between(-400, 400), rand_between(-2, 2),
                                        1'b0, $urandom(), $urandom(), volts));
                end
                sent += run_len;
            end else if (kind < 45) begin
                send_tick(make_tick(1'b0, rand_between(-1200, 400), rand_between(-60, 60),
                                    ($urandom_range(4) == 0), rand_between(-8000, 8000),
                                    rand_between(-4000, 4000), $urandom()));
                sent++;
            end else if (kind < 65) begin
                send_tick(make_tick(1'b1, rand_between(-1200, 400), rand_between(-60, 60),
                                    ($urandom_range(4) == 0), $urandom(), $urandom(),
                                    $urandom()));
                sent++;
            end else begin
                send_tick(make_tick($urandom_range(1), $urandom(), $urandom(),
                                    $urandom_range(1), $urandom(), $urandom(), $urandom()));
                sent++;
            end
        end
    endtask

    // extremes, both modes and each safety stage at reset settings
    task automatic test_directed_cases();
        int j;
        send_tick(make_tick(1'b0, 0, 0, 1'b0, 0, 0, 0));
        send_tick(make_tick(1'b0, 32767, 32767, 1'b0, 32767, 32767, 32767));
        send_tick(make_tick(1'b0, -32768, -32768, 1'b0, -32768, -32768, -32768));
        send_tick(make_tick(1'b1, 32767, -32768, 1'b0, 0, 0, 32767));
        send_tick(make_tick(1'b1, -32768, 32767, 1'b0, 0, 0, -32768));
        // past the top soft limit with positive drive
        send_tick(make_tick(1'b1, -900, 100, 1'b0, 0, 0, 2000));
        // bottom sensor: two zeroing requests, then homed
        send_tick(make_tick(1'b1, 300, 50, 1'b1, 0, 0, -3000));
        send_tick(make_tick(1'b1, 300, 50, 1'b1, 0, 0, -3000));
        send_tick(make_tick(1'b1, 300, 50, 1'b1, 0, 0, -3000));
        send_tick(make_tick(1'b0, 0, 0, 1'b1, 0, 0, 0));
        // clip on both sides
        send_tick(make_tick(1'b1, 0, 100, 1'b0, 0, 0, 20000));
        send_tick(make_tick(1'b1, 0, 100, 1'b0, 0, 0, -20000));
        // held drive with no motion until the stall cutoff
        for (j = 0; j < 12; j++) begin
            send_tick(make_tick(1'b1, 0, 0, 1'b0, 0, 0, 8000));
        end
        send_tick(make_tick(1'b1, 0, 100, 1'b0, 0, 0, 8000));
    endtask

    task automatic test_reset_settings();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_ticks(100);
    endtask

    task automatic test_max_settings();
        t_cfg c;
        c.position_gain    = 16'hffff;
        c.velocity_gain    = 16'hffff;
        c.feedforward_gain = 16'hffff;
        c.gravity_gain     = 15'h7fff;
        c.top_limit        = 16'sh7fff;
        c.stall_speed      = 15'h7fff;
        c.stall_voltage    = 15'h7fff;
        c.max_voltage      = 15'h7fff;
        load_config(c);
        send_idle_pct  = 83;
        recv_stall_pct = 0;
        run_random_ticks(80);
    endtask

    task automatic test_min_settings();
        t_cfg c;
        c = '0;
        c.top_limit = 16'sh8000;
        load_config(c);
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        run_random_ticks(60);
    endtask

    task automatic test_random_settings(input int unsigned send_pct, input int unsigned recv_pct);
        t_cfg c;
        c.position_gain    = $urandom();
        c.velocity_gain    = $urandom();
        c.feedforward_gain = $urandom();
        c.gravity_gain     = $urandom();
        c.top_limit        = $urandom();
        c.stall_speed      = $urandom_range(2000);
        c.stall_voltage    = $urandom_range(12000);
        c.max_voltage      = $urandom_range(16000, 2000);
        load_config(c);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        run_random_ticks(80);
    endtask

    // receiver backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each duty item with the oldest expectation
    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            error_count++;
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (duty_expected.size() == 0) begin
                error_count++;
                $display("%0t unexpected item expected none actual %h", $time, m_axis_tdata);
            end else begin
                duty_want = duty_expected.pop_front();
                check_field("motor_duty", duty_want.motor_duty,
                            $signed(m_axis_tdata[15:0]));
                check_field("safety_code", duty_want.safety_code, m_axis_tdata[18:16]);
                check_field("zero_request", duty_want.zero_request, m_axis_tdata[19]);
                check_field("stall_latched", duty_want.stall_latched, m_axis_tdata[20]);
                check_field("initialized", duty_want.initialized, m_axis_tdata[21]);
            end
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int i;
        for (i = 0; i < COS_TABLE_DEPTH; i++) begin
            cosine_lut[i] = cosine_q14((Q28_TWO_PI * i) / COS_TABLE_DEPTH + Q28_BIAS);
        end
        drive_cfg.position_gain    = 16'd42271;
        drive_cfg.velocity_gain    = 16'd258;
        drive_cfg.feedforward_gain = 16'd20825;
        drive_cfg.gravity_gain     = 15'd1331;
        drive_cfg.top_limit        = 16'sd6472;
        drive_cfg.stall_speed      = 15'd205;
        drive_cfg.stall_voltage    = 15'd4096;
        drive_cfg.max_voltage      = 15'd12288;
        stall_ticks = '0;
        stall_seen  = 1'b0;
        zero_pulses = '0;
        homed       = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_reset_settings();
        test_max_settings();
        test_min_settings();
        test_random_settings(34, 34);
        test_random_settings(0, 0);
        drain_pipe();

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
